// ===== rtl/pe_pkg.sv =====
// ----------------------------------------------------------------------------
// pe_pkg
// Shared types and constants for the fixed-point Horner polynomial evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pe_pkg;

   localparam int NUM_COEFS         = 8;
   localparam int COEF_INDEX_WIDTH  = 3;
   localparam int CSR_INDEX_WIDTH   = 4;
   localparam int COEF_WIDTH        = 32;
   localparam int POINT_WIDTH       = 16;
   localparam int PROD_WIDTH        = COEF_WIDTH + POINT_WIDTH;
   localparam int FRAC_SHIFT        = 14;
   localparam int SUM_WIDTH         = PROD_WIDTH + 1 - FRAC_SHIFT + 1;

   localparam logic signed [COEF_WIDTH-1:0] ACC_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COEF_WIDTH-1:0] ACC_MIN = 32'sh8000_0000;
   localparam logic signed [PROD_WIDTH:0]   ROUND_HALF = 49'sd8192;

   typedef struct packed {
      logic mul_en;
      logic sum_en;
   } cell_ctl_type;

   typedef struct packed {
      logic mul_valid;
      logic sum_valid;
   } cell_sts_type;

endpackage

`default_nettype wire

// ===== rtl/polynomial_evaluator.sv =====
// a req_ transfer passes through both stages of every cell before rsp_valid
// throughput: one point per cycle while rsp_ready does not stall, set by the chain of Horner cells
// each cell holds a multiply stage and a round/add/saturate stage
// stages advance independently, so bubbles collapse under rsp_ready stalls
// reset clears all stage valids and sets every coefficient to zero
// ----------------------------------------------------------------------------
// polynomial_evaluator
// Fixed-point Horner evaluation of a polynomial of up to degree seven.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_evaluator #(
   parameter int MAX_DEGREE = 7
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output      logic                                      req_ready,
   input  wire logic signed [pe_pkg::POINT_WIDTH-1:0]     req_point,
   output      logic                                      rsp_valid,
   input  wire logic                                      rsp_ready,
   output      logic signed [pe_pkg::COEF_WIDTH-1:0]      rsp_value,
   output      logic                                      rsp_overflow,
   input  wire logic                                      csr_valid,
   output      logic                                      csr_ready,
   input  wire logic [pe_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  wire logic [pe_pkg::COEF_WIDTH-1:0]             csr_data
);

   logic signed [pe_pkg::COEF_WIDTH-1:0]  coef_ff [pe_pkg::NUM_COEFS];

   pe_pkg::cell_ctl_type                  ctl [MAX_DEGREE];
   pe_pkg::cell_sts_type                  sts [MAX_DEGREE];
   logic                                  next_en [MAX_DEGREE];

   logic                                  link_valid [MAX_DEGREE+1];
   logic signed [pe_pkg::COEF_WIDTH-1:0]  link_acc   [MAX_DEGREE+1];
   logic signed [pe_pkg::POINT_WIDTH-1:0] link_x     [MAX_DEGREE+1];
   logic                                  link_ovf   [MAX_DEGREE+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pe_pkg::NUM_COEFS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready &&
                   csr_index < pe_pkg::CSR_INDEX_WIDTH'(pe_pkg::NUM_COEFS)) begin
         coef_ff[csr_index[pe_pkg::COEF_INDEX_WIDTH-1:0]] <= $signed(csr_data);
      end
   end

   assign link_valid[0] = req_valid;
   assign link_acc[0]   = coef_ff[pe_pkg::COEF_INDEX_WIDTH'(MAX_DEGREE)];
   assign link_x[0]     = req_point;
   assign link_ovf[0]   = 1'b0;

   for (genvar g = 0; g < MAX_DEGREE; g++) begin : g_cell
      if (g == MAX_DEGREE - 1) begin : g_last
         assign next_en[g] = rsp_ready;
      end else begin : g_mid
         assign next_en[g] = ctl[g+1].mul_en;
      end

      assign ctl[g].sum_en = !sts[g].sum_valid || next_en[g];
      assign ctl[g].mul_en = !sts[g].mul_valid || ctl[g].sum_en;
      assign link_valid[g+1] = sts[g].sum_valid;

      pe_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl[g]),
         .sts      (sts[g]),
         .in_valid (link_valid[g]),
         .in_acc   (link_acc[g]),
         .in_x     (link_x[g]),
         .in_ovf   (link_ovf[g]),
         .coef     (coef_ff[pe_pkg::COEF_INDEX_WIDTH'(MAX_DEGREE - 1 - g)]),
         .out_acc  (link_acc[g+1]),
         .out_x    (link_x[g+1]),
         .out_ovf  (link_ovf[g+1])
      );
   end

   assign req_ready    = ctl[0].mul_en;
   assign rsp_valid    = link_valid[MAX_DEGREE];
   assign rsp_value    = link_acc[MAX_DEGREE];
   assign rsp_overflow = link_ovf[MAX_DEGREE];

endmodule

`default_nettype wire

// ===== rtl/pe_cell.sv =====
// ----------------------------------------------------------------------------
// pe_cell
// One Horner step: a multiply stage followed by a round, add and saturate stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pe_cell (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire pe_pkg::cell_ctl_type                      ctl,
   output      pe_pkg::cell_sts_type                      sts,
   input  wire logic                                      in_valid,
   input  wire logic signed [pe_pkg::COEF_WIDTH-1:0]      in_acc,
   input  wire logic signed [pe_pkg::POINT_WIDTH-1:0]     in_x,
   input  wire logic                                      in_ovf,
   input  wire logic signed [pe_pkg::COEF_WIDTH-1:0]      coef,
   output      logic signed [pe_pkg::COEF_WIDTH-1:0]      out_acc,
   output      logic signed [pe_pkg::POINT_WIDTH-1:0]     out_x,
   output      logic                                      out_ovf
);

   logic                                      mul_valid_ff;
   logic signed [pe_pkg::PROD_WIDTH-1:0]      prod_ff;
   logic signed [pe_pkg::PROD_WIDTH-1:0]      prod_in;
   logic signed [pe_pkg::POINT_WIDTH-1:0]     mul_x_ff;
   logic                                      mul_ovf_ff;

   logic                                      sum_valid_ff;
   logic signed [pe_pkg::COEF_WIDTH-1:0]      acc_ff;
   logic signed [pe_pkg::COEF_WIDTH-1:0]      acc_in;
   logic signed [pe_pkg::POINT_WIDTH-1:0]     sum_x_ff;
   logic                                      sum_ovf_ff;
   logic                                      ovf_in;

   logic signed [pe_pkg::PROD_WIDTH:0]        rounded;
   logic signed [pe_pkg::SUM_WIDTH-2:0]       shifted;
   logic signed [pe_pkg::SUM_WIDTH-1:0]       sum;

   assign prod_in = pe_pkg::PROD_WIDTH'(in_acc) * pe_pkg::PROD_WIDTH'(in_x);

   always_comb begin
      rounded = (pe_pkg::PROD_WIDTH+1)'(prod_ff) + pe_pkg::ROUND_HALF;
      shifted = rounded[pe_pkg::PROD_WIDTH:pe_pkg::FRAC_SHIFT];
      sum     = pe_pkg::SUM_WIDTH'(shifted) + pe_pkg::SUM_WIDTH'(coef);
      acc_in  = sum[pe_pkg::COEF_WIDTH-1:0];
      ovf_in  = mul_ovf_ff;
      if (sum > pe_pkg::SUM_WIDTH'(pe_pkg::ACC_MAX)) begin
         acc_in = pe_pkg::ACC_MAX;
         ovf_in = 1'b1;
      end else if (sum < pe_pkg::SUM_WIDTH'(pe_pkg::ACC_MIN)) begin
         acc_in = pe_pkg::ACC_MIN;
         ovf_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (ctl.mul_en) begin
            mul_valid_ff <= in_valid;
         end
         if (ctl.sum_en) begin
            sum_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff    <= prod_in;
         mul_x_ff   <= in_x;
         mul_ovf_ff <= in_ovf;
      end
      if (ctl.sum_en) begin
         acc_ff     <= acc_in;
         sum_x_ff   <= mul_x_ff;
         sum_ovf_ff <= ovf_in;
      end
   end

   assign sts.mul_valid = mul_valid_ff;
   assign sts.sum_valid = sum_valid_ff;
   assign out_acc       = acc_ff;
   assign out_x         = sum_x_ff;
   assign out_ovf       = sum_ovf_ff;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fixed-point Horner polynomial evaluator. A
// scoreboard predicts value and saturation flag for every accepted point
// from its own copy of the coefficient registers. The bench runs directed
// corners, then random phases that each reload the coefficients while idle.
// It applies random gaps on both channels, one long response hold-off, and
// drains between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   localparam int POLY_DEGREE  = 7;
   localparam int CLOCK_PERIOD = 4;
   localparam int PHASE_COUNT  = 16;
   localparam int PHASE_POINTS = 26;

   class horner_scoreboard;
      typedef struct packed {
         logic signed [pe_pkg::POINT_WIDTH-1:0] point;
         logic signed [pe_pkg::COEF_WIDTH-1:0]  value;
         logic                                  overflow;
      } poly_result_type;

      logic signed [pe_pkg::COEF_WIDTH-1:0] coef [pe_pkg::NUM_COEFS];
      poly_result_type                      pending_results [$];
      int unsigned                          error_count;

      function new();
         foreach (coef[i]) coef[i] = '0;
         error_count = 0;
      endfunction

      function void write_coef(logic [pe_pkg::CSR_INDEX_WIDTH-1:0] idx,
                               logic [pe_pkg::COEF_WIDTH-1:0] data);
         if (idx < pe_pkg::NUM_COEFS) coef[idx[pe_pkg::COEF_INDEX_WIDTH-1:0]] = data;
      endfunction

      function poly_result_type horner_eval(logic signed [pe_pkg::POINT_WIDTH-1:0] x);
         poly_result_type res;
         longint          acc;
         longint          sum;
         logic            sat;
         acc = longint'(coef[POLY_DEGREE]);
         sat = 1'b0;
         for (int i = POLY_DEGREE - 1; i >= 0; i--) begin
            sum = ((acc * longint'(x) + 64'sd8192) >>> pe_pkg::FRAC_SHIFT) +
                  longint'(coef[i]);
            if (sum > longint'(pe_pkg::ACC_MAX)) begin
               sum = longint'(pe_pkg::ACC_MAX);
               sat = 1'b1;
            end else if (sum < longint'(pe_pkg::ACC_MIN)) begin
               sum = longint'(pe_pkg::ACC_MIN);
               sat = 1'b1;
            end
            acc = sum;
         end
         res.point    = x;
         res.value    = acc[pe_pkg::COEF_WIDTH-1:0];
         res.overflow = sat;
         return res;
      endfunction

      function void note_point(logic signed [pe_pkg::POINT_WIDTH-1:0] x);
         pending_results.push_back(horner_eval(x));
      endfunction

      function void report_error(string msg);
         error_count++;
         if (error_count <= 10) $display("error: %s", msg);
      endfunction

      function void check_result(logic signed [pe_pkg::COEF_WIDTH-1:0] value, logic overflow);
         poly_result_type want;
         if (pending_results.size() == 0) begin
            report_error($sformatf("unrequested result value %h overflow %b", value, overflow));
            return;
         end
         want = pending_results.pop_front();
         if (value !== want.value || overflow !== want.overflow)
            report_error($sformatf("point %h: wanted value %h overflow %b, got value %h overflow %b",
                                   want.point, want.value, want.overflow, value, overflow));
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic                                   clock        = 1'b0;
   logic                                   reset        = 1'b1;
   logic                                   req_valid    = 1'b0;
   logic signed [pe_pkg::POINT_WIDTH-1:0]  req_point    = '0;
   logic                                   rsp_ready    = 1'b0;
   logic                                   csr_valid    = 1'b0;
   logic [pe_pkg::CSR_INDEX_WIDTH-1:0]     csr_index    = '0;
   logic [pe_pkg::COEF_WIDTH-1:0]          csr_data     = '0;
   wire logic                              req_ready;
   wire logic                              rsp_valid;
   wire logic signed [pe_pkg::COEF_WIDTH-1:0] rsp_value;
   wire logic                              rsp_overflow;
   wire logic                              csr_ready;

   horner_scoreboard              sb;
   logic [pe_pkg::COEF_WIDTH-1:0] coef_set [pe_pkg::NUM_COEFS];
   bit                            req_burst       = 1'b0;
   bit                            rsp_burst       = 1'b0;
   int                            rsp_hold_cycles = 0;

   polynomial_evaluator #(
      .MAX_DEGREE (POLY_DEGREE)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_point    (req_point),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_value    (rsp_value),
      .rsp_overflow (rsp_overflow),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #200_000;
      $display("status: fail");
      $finish;
   end

   task automatic send_point(input logic signed [pe_pkg::POINT_WIDTH-1:0] x);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point <= x;
      do @(posedge clock); while (!req_ready);
      sb.note_point(x);
   endtask

   task automatic stop_points();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [pe_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [pe_pkg::COEF_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_coef(idx, data);
   endtask

   task automatic load_coefs(input bit with_stray);
      for (int i = 0; i < pe_pkg::NUM_COEFS; i++) begin
         write_reg(pe_pkg::CSR_INDEX_WIDTH'(i), coef_set[i]);
         if (with_stray && i == 3)
            write_reg(pe_pkg::CSR_INDEX_WIDTH'(pe_pkg::NUM_COEFS +
                      $urandom_range(0, pe_pkg::NUM_COEFS - 1)), $urandom);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic void fill_coefs(logic [pe_pkg::COEF_WIDTH-1:0] v);
      foreach (coef_set[i]) coef_set[i] = v;
   endfunction

   function automatic logic [pe_pkg::COEF_WIDTH-1:0] random_coef(int mode, int idx);
      case (mode)
         0: return $urandom;
         1: return pe_pkg::COEF_WIDTH'($urandom_range(0, 1 << 19) - (1 << 18));
         2: begin
            case ($urandom_range(0, 4))
               0: return pe_pkg::ACC_MAX;
               1: return pe_pkg::ACC_MIN;
               2: return '0;
               3: return 32'sd1;
               default: return -32'sd1;
            endcase
         end
         default: return (idx <= 3) ?
                         pe_pkg::COEF_WIDTH'($urandom_range(0, 1 << 19) - (1 << 18)) : '0;
      endcase
   endfunction

   function automatic logic signed [pe_pkg::POINT_WIDTH-1:0] random_point(int mode);
      case (mode)
         0: return pe_pkg::POINT_WIDTH'($urandom);
         1: return pe_pkg::POINT_WIDTH'($urandom_range(0, 32767) - 16384);
         default: begin
            case ($urandom_range(0, 3))
               0: return 16'sh7fff;
               1: return 16'sh8000;
               2: return '0;
               default: return pe_pkg::POINT_WIDTH'($urandom);
            endcase
         end
      endcase
   endfunction

   // result channel: per-result stall, optional long hold-off
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = rsp_burst ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_value, rsp_overflow);
      end
   end

   initial begin
      int coef_mode;
      int point_mode;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // coefficients at reset value
      send_point('0);
      send_point(16'sh7fff);
      send_point(16'sh8000);
      stop_points();
      wait_idle();

      // all coefficients 1.0
      fill_coefs(32'sh0001_0000);
      load_coefs(1'b0);
      send_point('0);
      send_point(16'sd16384);
      send_point(-16'sd16384);
      send_point(16'sh7fff);
      send_point(16'sh8000);
      stop_points();
      wait_idle();

      // saturation at the top
      fill_coefs(pe_pkg::ACC_MAX);
      load_coefs(1'b0);
      send_point(16'sh8000);
      send_point(16'sh7fff);
      send_point('0);
      stop_points();
      wait_idle();

      // saturation at the bottom
      fill_coefs(pe_pkg::ACC_MIN);
      load_coefs(1'b0);
      send_point(16'sh8000);
      send_point(16'sh7fff);
      stop_points();
      wait_idle();

      // rounding ties on one lsb
      fill_coefs('0);
      coef_set[POLY_DEGREE] = 32'sd1;
      load_coefs(1'b0);
      send_point(16'sd8192);
      send_point(-16'sd8192);
      send_point(16'sd24576);
      stop_points();
      wait_idle();

      // writes above the coefficient range are dropped
      fill_coefs('0);
      coef_set[0] = 32'h1234_5678;
      load_coefs(1'b0);
      for (int i = pe_pkg::NUM_COEFS; i < (1 << pe_pkg::CSR_INDEX_WIDTH); i++)
         write_reg(pe_pkg::CSR_INDEX_WIDTH'(i), $urandom);
      csr_valid <= 1'b0;
      @(posedge clock);
      send_point('0);
      send_point(16'sd16384);
      stop_points();
      wait_idle();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         coef_mode = $urandom_range(0, 3);
         for (int i = 0; i < pe_pkg::NUM_COEFS; i++) coef_set[i] = random_coef(coef_mode, i);
         load_coefs(phase % 3 == 0);
         req_burst  = ($urandom_range(0, 3) == 0);
         rsp_burst  = ($urandom_range(0, 3) == 0);
         point_mode = $urandom_range(0, 2);
         if (phase == PHASE_COUNT / 2) begin
            rsp_hold_cycles = 80;
            req_burst       = 1'b1;
            repeat (2 * PHASE_POINTS) send_point(random_point(point_mode));
         end else begin
            repeat (PHASE_POINTS) send_point(random_point(point_mode));
         end
         stop_points();
      end

      wait_idle();
      repeat (4 * POLY_DEGREE) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/pe_pkg.sv
rtl/pe_cell.sv
rtl/polynomial_evaluator.sv
dv/testbench.sv
